FILE: sv/mtfe_pkg.sv
// ============================================================================
// Multi-tap echo package
// Shared constants, configuration register codes, controller states and the
// command and status bundles between the controller and the datapath.
// ============================================================================
package mtfe_pkg;

    // Default values of the top-level parameters.
    localparam int RING_DEPTH_DEFAULT  = 65536;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int MAX_TAPS_DEFAULT    = 8;

    // Fixed arithmetic constants.
    localparam int MIN_DELAY   = 10;
    localparam int FRAC_BITS   = 28;
    localparam int WEIGHT_BITS = 32;
    localparam int UNITY_DECAY = 65536;

    // Register widths.
    localparam int DELAY_BITS = 16;
    localparam int TAPS_BITS  = 4;
    localparam int DECAY_BITS = 17;
    localparam int SCALE_BITS = 16;

    // Tap counter width; covers tap counts up to 31.
    localparam int TAP_CNT_BITS = 5;
    localparam int TAP_SLOTS    = 2 ** TAP_CNT_BITS;

    // Configuration port widths.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;

    // Register reset values.
    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd1488;
    localparam logic [TAPS_BITS-1:0]  TAPS_RESET  = 4'd4;
    localparam logic [DECAY_BITS-1:0] DECAY_RESET = 17'd58982;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd4096;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DELAY_LENGTH = 2'd0,
        CFG_TAP_COUNT    = 2'd1,
        CFG_DECAY_FACTOR = 2'd2,
        CFG_OUTPUT_SCALE = 2'd3
    } cfg_index_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [TAP_CNT_BITS-1:0] taps_eff;
        logic                    busy;
    } ctrl_status_t;

endpackage

FILE: sv/mtfe_if.sv
// ============================================================================
// Multi-tap echo channel interfaces
// Valid/ready channels for input samples, output samples and register writes.
// ============================================================================

// Input sample channel.
interface mtfe_in_if #(
    parameter int SAMPLE_BITS = mtfe_pkg::SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// Output sample channel.
interface mtfe_out_if #(
    parameter int SAMPLE_BITS = mtfe_pkg::SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// Register write channel.
interface mtfe_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mtfe_pkg::CFG_INDEX_BITS-1:0] reg_index;
    logic [mtfe_pkg::CFG_DATA_BITS-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: sv/mtfe_ctrl.sv
// ============================================================================
// Multi-tap echo controller
// Sequences one sample: accept, one echo read per cycle, pipeline drain and
// hand-off into the output register.
// ============================================================================
module mtfe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  mtfe_pkg::ctrl_status_t status,
    output mtfe_pkg::ctrl_cmd_t    cmd
);

    mtfe_pkg::ctrl_state_t                state_reg, state_next;
    logic [mtfe_pkg::TAP_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 accept;
    logic                                 out_free;

    assign accept   = in_valid && (state_reg == mtfe_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Next state and remaining echo reads.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            mtfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = status.taps_eff - mtfe_pkg::TAP_CNT_BITS'(1);
                    if (status.taps_eff > mtfe_pkg::TAP_CNT_BITS'(1))
                    begin
                        state_next = mtfe_pkg::ST_ISSUE;
                    end
                    else
                    begin
                        state_next = mtfe_pkg::ST_DRAIN;
                    end
                end
            end
            mtfe_pkg::ST_ISSUE:
            begin
                cnt_next = cnt_reg - mtfe_pkg::TAP_CNT_BITS'(1);
                if (cnt_reg == mtfe_pkg::TAP_CNT_BITS'(1))
                begin
                    state_next = mtfe_pkg::ST_DRAIN;
                end
            end
            mtfe_pkg::ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = mtfe_pkg::ST_FINISH;
                end
            end
            mtfe_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mtfe_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Commands and input handshake.
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            mtfe_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            mtfe_pkg::ST_ISSUE:
            begin
                cmd.issue = 1'b1;
            end
            mtfe_pkg::ST_DRAIN:
            begin
                cmd.issue = 1'b0;
            end
            mtfe_pkg::ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
        endcase
    end

    // The output register is full until its transaction completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtfe_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/mtfe_datapath.sv
// ============================================================================
// Multi-tap echo datapath
// Configuration registers, ring memory with write pointer, weight update,
// tap multiplier, accumulator and the saturating output register.
// ============================================================================
module mtfe_datapath #(
    parameter int RING_DEPTH  = mtfe_pkg::RING_DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = mtfe_pkg::SAMPLE_BITS_DEFAULT,
    parameter int MAX_TAPS    = mtfe_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtfe_pkg::ctrl_cmd_t                 cmd,
    output mtfe_pkg::ctrl_status_t              status,
    input  logic                                cfg_valid,
    input  logic [mtfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mtfe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int DW   = (AW > mtfe_pkg::DELAY_BITS) ? AW : mtfe_pkg::DELAY_BITS;
    localparam int WB   = mtfe_pkg::WEIGHT_BITS;
    localparam int DB   = mtfe_pkg::DECAY_BITS;
    localparam int PW   = SAMPLE_BITS + WB + 1;
    localparam int ACCW = SAMPLE_BITS + WB + mtfe_pkg::TAP_CNT_BITS;
    localparam int TW   = mtfe_pkg::TAP_CNT_BITS;
    localparam logic signed [ACCW-1:0] SAT_MAX = ACCW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACCW-1:0] SAT_MIN = ~SAT_MAX;

    // Step back by one delay around the ring.
    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] p,
                                               input logic [AW-1:0] d);
        logic [AW:0] wrap_sum;
        wrap_sum = {1'b0, p} + (AW+1)'(RING_DEPTH) - {1'b0, d};
        return (p >= d) ? (p - d) : wrap_sum[AW-1:0];
    endfunction

    // Configuration registers.
    logic [mtfe_pkg::DELAY_BITS-1:0] delay_reg;
    logic [mtfe_pkg::TAPS_BITS-1:0]  taps_reg;
    logic [mtfe_pkg::DECAY_BITS-1:0] decay_reg;
    logic [mtfe_pkg::SCALE_BITS-1:0] scale_reg;

    // Ring memory and its write side.
    logic signed [SAMPLE_BITS-1:0] echo_mem [RING_DEPTH];
    logic [AW-1:0]                 wp_reg;
    logic                          wrapped_reg;

    // Per-sample working registers.
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [DB-1:0]                 dec_reg;
    logic [AW-1:0]                 d_reg;
    logic [AW-1:0]                 ptr_reg;
    logic [WB-1:0]                 weight_reg;
    logic signed [SAMPLE_BITS-1:0] mem_q_reg;
    logic                          direct_reg;
    logic                          mask_reg;
    logic                          op_vld_reg;
    logic signed [PW-1:0]          prod_reg;
    logic                          prod_vld_reg;
    logic signed [ACCW-1:0]        acc_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    // Combinational values.
    logic [TW-1:0]                 taps_ext;
    logic [TW-1:0]                 taps_eff;
    logic [AW-1:0]                 hi_tab [mtfe_pkg::TAP_SLOTS];
    logic [AW-1:0]                 hi_sel;
    logic [DW-1:0]                 delay_ext;
    logic [DW-1:0]                 hi_ext;
    logic [AW-1:0]                 d_min;
    logic [AW-1:0]                 d_eff;
    logic [DB-1:0]                 dec_eff;
    logic [WB+DB-1:0]              wprod;
    logic signed [SAMPLE_BITS-1:0] op;
    logic signed [PW-1:0]          op_ext;
    logic signed [PW-1:0]          w_ext;
    logic signed [ACCW-1:0]        q;
    logic signed [SAMPLE_BITS-1:0] q_sat;

    // Longest allowed delay for each tap count.
    for (genvar t = 0; t < mtfe_pkg::TAP_SLOTS; t++)
    begin : g_hi
        localparam int HI = (t == 0) ? 0 : RING_DEPTH / ((t == 0) ? 1 : t) - 1;
        assign hi_tab[t] = AW'(HI);
    end

    // Effective tap count, delay and decay.
    assign taps_ext = TW'(taps_reg);
    assign taps_eff = (taps_ext == '0) ? TW'(1)
                    : (taps_ext > TW'(MAX_TAPS)) ? TW'(MAX_TAPS) : taps_ext;
    assign hi_sel    = hi_tab[taps_eff];
    assign delay_ext = DW'(delay_reg);
    assign hi_ext    = DW'(hi_sel);
    assign d_min     = (delay_ext > hi_ext) ? hi_sel : delay_ext[AW-1:0];
    assign d_eff     = (d_min < AW'(mtfe_pkg::MIN_DELAY)) ? AW'(mtfe_pkg::MIN_DELAY) : d_min;
    assign dec_eff   = (decay_reg > DB'(mtfe_pkg::UNITY_DECAY))
                     ? DB'(mtfe_pkg::UNITY_DECAY) : decay_reg;

    assign status.taps_eff = taps_eff;
    assign status.busy     = op_vld_reg || prod_vld_reg;

    // Next echo weight: weight times decay in Q1.16, truncated.
    assign wprod = (WB+DB)'(weight_reg) * (WB+DB)'(dec_reg);

    // Multiplier operand: the direct sample, or the memory word when written.
    assign op     = direct_reg ? sample_reg : (mask_reg ? mem_q_reg : '0);
    assign op_ext = PW'(op);
    assign w_ext  = $signed({{(PW-WB){1'b0}}, weight_reg});

    // Floor shift of the sum, then saturation to the sample range.
    assign q     = acc_reg >>> mtfe_pkg::FRAC_BITS;
    assign q_sat = (q > SAT_MAX) ? SAT_MAX[SAMPLE_BITS-1:0]
                 : (q < SAT_MIN) ? SAT_MIN[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];

    assign sample_out = out_data_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= mtfe_pkg::DELAY_RESET;
            taps_reg  <= mtfe_pkg::TAPS_RESET;
            decay_reg <= mtfe_pkg::DECAY_RESET;
            scale_reg <= mtfe_pkg::SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (mtfe_pkg::cfg_index_t'(cfg_index))
                mtfe_pkg::CFG_DELAY_LENGTH: delay_reg <= cfg_data[mtfe_pkg::DELAY_BITS-1:0];
                mtfe_pkg::CFG_TAP_COUNT:    taps_reg  <= cfg_data[mtfe_pkg::TAPS_BITS-1:0];
                mtfe_pkg::CFG_DECAY_FACTOR: decay_reg <= cfg_data[mtfe_pkg::DECAY_BITS-1:0];
                mtfe_pkg::CFG_OUTPUT_SCALE: scale_reg <= cfg_data[mtfe_pkg::SCALE_BITS-1:0];
            endcase
        end
    end

    // Write pointer and fill tracking; an entry below the pointer, or any
    // entry once the ring has wrapped, holds a stored sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (wp_reg == AW'(RING_DEPTH - 1))
            begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + AW'(1);
            end
        end
    end

    // Ring memory write port; the new sample never lands on a tap address.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            echo_mem[wp_reg] <= sample_in;
        end
    end

    // Ring memory read port.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            mem_q_reg <= echo_mem[ptr_reg];
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            op_vld_reg   <= cmd.accept || cmd.issue;
            prod_vld_reg <= op_vld_reg;
        end
    end

    // Sample set-up, weight and pointer stepping, tap product and sum.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample_in;
            dec_reg    <= dec_eff;
            d_reg      <= d_eff;
            ptr_reg    <= ring_sub(wp_reg, d_eff);
            weight_reg <= {scale_reg, 16'd0};
            direct_reg <= 1'b1;
            mask_reg   <= 1'b1;
            acc_reg    <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                ptr_reg    <= ring_sub(ptr_reg, d_reg);
                weight_reg <= wprod[WB+15:16];
                direct_reg <= 1'b0;
                mask_reg   <= wrapped_reg || (ptr_reg < wp_reg);
            end
            if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACCW'(prod_reg);
            end
        end
        prod_reg <= op_ext * w_ext;
        if (cmd.load_out)
        begin
            out_data_reg <= q_sat;
        end
    end

endmodule

FILE: sv/multi_tap_feedforward_echo_unit.sv
// ============================================================================
// Multi-tap feed-forward echo unit
// Mixes each input sample with equally spaced, decaying echoes from a ring.
// ============================================================================
// Usage:
// The in_chan channel takes one signed sample per transaction; out_chan
// returns one echo-mixed, saturated sample per input, in order. cfg_chan
// writes delay_length (0), tap_count (1), decay_factor (2) and output_scale
// (3); it is always ready, and it is to be written only while no sample is
// in flight, a rule on the user that the block itself does not enforce.
// The effective tap count runs from 1 to MAX_TAPS. The single read port of
// the ring memory reads one echo tap per cycle, followed by a three-stage
// multiply and sum pipeline. The next sample is accepted no earlier than
// the cycle after the result is loaded, so one sample is processed at a time.
// The output register holds a finished result while the receiver stalls; a
// new sample is taken meanwhile and waits for the register in its last step.
// Reset loads the register defaults, empties the output register and sets
// the write pointer to zero. Ring entries not yet written read as zero,
// tracked by the write pointer and a wrap flag, so no clearing pass is run.
// ============================================================================
module multi_tap_feedforward_echo_unit #(
    parameter int RING_DEPTH  = mtfe_pkg::RING_DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = mtfe_pkg::SAMPLE_BITS_DEFAULT,
    parameter int MAX_TAPS    = mtfe_pkg::MAX_TAPS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    mtfe_in_if.sink    in_chan,
    mtfe_out_if.source out_chan,
    mtfe_cfg_if.sink   cfg_chan
);

    mtfe_pkg::ctrl_cmd_t    cmd;
    mtfe_pkg::ctrl_status_t status;

    // Register writes are always taken.
    assign cfg_chan.ready = 1'b1;

    // Sample sequencing.
    mtfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_ready  (in_chan.ready),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, ring memory and registers.
    mtfe_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_chan.valid),
        .cfg_index  (cfg_chan.reg_index),
        .cfg_data   (cfg_chan.wdata),
        .sample_in  (in_chan.sample_in),
        .sample_out (out_chan.sample_out)
    );

`ifndef SYNTHESIS
    // A new sample only enters an empty multiply and sum pipeline.
    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !status.busy)
        else $error("sample accepted while the pipeline is busy");

    // Accept, tap read and result load never coincide.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.issue, cmd.load_out}))
        else $error("controller commands overlap");

    // A tap read keeps the pipeline busy on the next cycle.
    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> status.busy)
        else $error("tap read lost in the pipeline");

    // Loading a result presents it on the output channel.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_chan.valid)
        else $error("loaded result not presented");
`endif

endmodule

FILE: tb/testbench.sv
// ============================================================================
// Multi-tap echo unit testbench
// Drives signed samples and register writes into the echo unit under random
// idling on both sides. A scripted opening covers reset defaults, saturation,
// rounding toward minus infinity and the clamping of out-of-range registers.
// Random phases with varied register settings follow. Each output is checked
// against a scripted value or a local mixer with its own ring and registers.
// ============================================================================
module testbench;

    import mtfe_pkg::*;

    localparam int RING_DEPTH     = RING_DEPTH_DEFAULT;
    localparam int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT;
    localparam int MAX_TAPS       = MAX_TAPS_DEFAULT;
    localparam int RING_BITS      = $clog2(RING_DEPTH);
    localparam int PHASES         = 8;
    localparam int PHASE_SAMPLES  = 100;
    localparam int IDLE_PERCENT   = 18;
    localparam int STEADY_PHASE   = 3;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SCRIPT_LEN     = 30;

    localparam longint SAT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAT_MIN = -SAT_MAX - 64'sd1;

    typedef enum logic {
        STEP_WRITE,
        STEP_SAMPLE
    } step_kind_t;

    // One scripted step: a register write or a sample, with an optional
    // expected output typed in by hand.
    typedef struct packed {
        step_kind_t               kind;
        cfg_index_t               index;
        logic signed [16:0]       data;
        logic                     check;
        logic signed [15:0]       expected;
    } script_row_t;

    // Scripted opening. At reset the scale is unity and the ring is empty, so
    // the first outputs equal the inputs.
    script_row_t script [SCRIPT_LEN] = '{
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd0,      1'b1, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd32767,  1'b1, 16'sd32767},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, -17'sd32768, 1'b1, 16'sh8000},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, -17'sd1,     1'b1, -16'sd1},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd1,      1'b1, 16'sd1},
        // Largest scale: saturation at both ends and flooring of small values.
        '{STEP_WRITE,  CFG_OUTPUT_SCALE, 17'sd65535,  1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd32767,  1'b1, 16'sd32767},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, -17'sd32768, 1'b1, 16'sh8000},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd1,      1'b1, 16'sd15},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, -17'sd1,     1'b1, -16'sd16},
        // Zero scale silences everything.
        '{STEP_WRITE,  CFG_OUTPUT_SCALE, 17'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd12345,  1'b1, 16'sd0},
        // Tap count zero acts as one, delay zero as the minimum, and a decay
        // above one as exactly one.
        '{STEP_WRITE,  CFG_OUTPUT_SCALE, 17'sd4096,   1'b0, 16'sd0},
        '{STEP_WRITE,  CFG_TAP_COUNT,    17'sd0,      1'b0, 16'sd0},
        '{STEP_WRITE,  CFG_DELAY_LENGTH, 17'sd0,      1'b0, 16'sd0},
        '{STEP_WRITE,  CFG_DECAY_FACTOR, 17'sh1FFFF,  1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd100,    1'b1, 16'sd100},
        // A wide write to the tap count keeps four bits, fifteen, which acts
        // as the maximum; the echoes of the samples above now come back.
        '{STEP_WRITE,  CFG_TAP_COUNT,    17'sh1FFFF,  1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd20000,  1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, -17'sd20000, 1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd1000,   1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, -17'sd32768, 1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd32767,  1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd7,      1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, -17'sd7,     1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, CFG_DELAY_LENGTH, 17'sd0,      1'b0, 16'sd0}
    };

    logic clk;
    logic rst_n;

    mtfe_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_chan ();
    mtfe_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_chan ();
    mtfe_cfg_if                              cfg_chan ();

    multi_tap_feedforward_echo_unit #(
        .RING_DEPTH (RING_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_TAPS   (MAX_TAPS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .out_chan(out_chan),
        .cfg_chan(cfg_chan)
    );

    // Local copy of the registers and the echo ring.
    logic [DELAY_BITS-1:0]         echo_delay = DELAY_RESET;
    logic [TAPS_BITS-1:0]          echo_taps  = TAPS_RESET;
    logic [DECAY_BITS-1:0]         echo_decay = DECAY_RESET;
    logic [SCALE_BITS-1:0]         mix_scale  = SCALE_RESET;
    logic signed [SAMPLE_BITS-1:0] echo_ring [RING_DEPTH];
    logic [RING_BITS-1:0]          ring_head  = '0;

    logic signed [SAMPLE_BITS-1:0] expected_mix [$];
    logic signed [SAMPLE_BITS-1:0] oldest_mix;
    int                            mismatch_count = 0;
    int                            quiet_cycles   = 0;
    logic                          steady_flow    = 1'b0;

    // Mixes one dry sample with its echoes, then stores it in the ring.
    function automatic logic signed [SAMPLE_BITS-1:0] mix_echoes(
        input logic signed [SAMPLE_BITS-1:0] dry
    );
        int                   taps;
        int                   spacing;
        longint               decay;
        longint               weight;
        longint               acc;
        logic [RING_BITS-1:0] tap_pos;

        taps = int'(echo_taps);
        if (taps < 1)
            taps = 1;
        if (taps > MAX_TAPS)
            taps = MAX_TAPS;
        decay = longint'(echo_decay);
        if (decay > UNITY_DECAY)
            decay = UNITY_DECAY;

        // The delay is clamped so that all taps fit in the ring.
        spacing = int'(echo_delay);
        if (spacing > RING_DEPTH / taps - 1)
            spacing = RING_DEPTH / taps - 1;
        if (spacing < MIN_DELAY)
            spacing = MIN_DELAY;

        tap_pos = ring_head - RING_BITS'(spacing);
        weight  = longint'(mix_scale) << 16;
        acc     = longint'(dry) * weight;
        for (int k = 1; k < taps; k++)
        begin
            weight  = (weight * decay) >> 16;
            acc    += longint'(echo_ring[tap_pos]) * weight;
            tap_pos = tap_pos - RING_BITS'(spacing);
        end

        // Arithmetic shift floors toward minus infinity.
        acc = acc >>> FRAC_BITS;
        if (acc > SAT_MAX)
            acc = SAT_MAX;
        if (acc < SAT_MIN)
            acc = SAT_MIN;

        echo_ring[ring_head] = dry;
        ring_head            = ring_head + 1'b1;
        return acc[SAMPLE_BITS-1:0];
    endfunction

    // Offers one sample, at times after a random gap, and records its result.
    task automatic send_sample(
        input logic signed [SAMPLE_BITS-1:0] value,
        input logic                          check,
        input logic signed [SAMPLE_BITS-1:0] listed
    );
        logic signed [SAMPLE_BITS-1:0] mixed;

        if (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_chan.valid     <= 1'b1;
        in_chan.sample_in <= value;
        do
            @(posedge clk);
        while (!in_chan.ready);
        mixed = mix_echoes(value);
        expected_mix.push_back(check ? listed : mixed);
    endtask

    // Writes one register; the caller lowers valid after the last write.
    task automatic write_register(
        input cfg_index_t                index,
        input logic [CFG_DATA_BITS-1:0]  value
    );
        cfg_chan.valid     <= 1'b1;
        cfg_chan.reg_index <= index;
        cfg_chan.wdata     <= value;
        do
            @(posedge clk);
        while (!cfg_chan.ready);
        case (index)
            CFG_DELAY_LENGTH: echo_delay = value[DELAY_BITS-1:0];
            CFG_TAP_COUNT:    echo_taps  = value[TAPS_BITS-1:0];
            CFG_DECAY_FACTOR: echo_decay = value[DECAY_BITS-1:0];
            CFG_OUTPUT_SCALE: mix_scale  = value[SCALE_BITS-1:0];
            default: ;
        endcase
    endtask

    // Holds the sender off until every outstanding sample has come back.
    task automatic drain_results();
        in_chan.valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random back-pressure, none during the steady phase.
    initial
    begin
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_chan.ready <= rst_n && (steady_flow || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Output checker: each transaction against the oldest expected sample.
    always @(posedge clk)
    begin
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            if (expected_mix.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: sample_out %0d arrived with nothing expected",
                         $time, out_chan.sample_out);
            end
            else
            begin
                oldest_mix = expected_mix.pop_front();
                if (out_chan.sample_out !== oldest_mix)
                begin
                    mismatch_count++;
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, oldest_mix, out_chan.sample_out);
                end
            end
        end
    end

    // Watchdog: counts cycles in which no channel moves a transaction.
    always @(posedge clk)
    begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
            || (cfg_chan.valid && cfg_chan.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus: scripted opening, then random phases with new settings.
    initial
    begin
        in_chan.valid      <= 1'b0;
        in_chan.sample_in  <= '0;
        cfg_chan.valid     <= 1'b0;
        cfg_chan.reg_index <= CFG_DELAY_LENGTH;
        cfg_chan.wdata     <= '0;
        rst_n              <= 1'b0;
        foreach (echo_ring[i])
            echo_ring[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the script; writes wait until nothing is in flight.
        foreach (script[i])
        begin
            if (script[i].kind == STEP_WRITE)
            begin
                drain_results();
                write_register(script[i].index, script[i].data);
            end
            else
            begin
                cfg_chan.valid <= 1'b0;
                send_sample(script[i].data[15:0], script[i].check, script[i].expected);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            logic [CFG_DATA_BITS-1:0] delay_val;
            logic [CFG_DATA_BITS-1:0] taps_val;
            logic [CFG_DATA_BITS-1:0] decay_val;
            logic [CFG_DATA_BITS-1:0] scale_val;

            drain_results();
            steady_flow = (phase == STEADY_PHASE);

            // The first two phases use fixed settings, with delay and decay at both ends.
            case (phase)
                0:
                begin
                    delay_val = 17'd10;
                    taps_val  = 17'd8;
                    decay_val = 17'(UNITY_DECAY);
                    scale_val = 17'hFFFF;
                end
                1:
                begin
                    delay_val = 17'hFFFF;
                    taps_val  = 17'd2;
                    decay_val = 17'd0;
                    scale_val = 17'd4096;
                end
                default:
                begin
                    case ($urandom_range(5))
                        0:       delay_val = 17'($urandom_range(12));
                        1:       delay_val = 17'($urandom);
                        default: delay_val = 17'($urandom_range(60, 10));
                    endcase
                    if ($urandom_range(3) == 0)
                        taps_val = 17'($urandom);
                    else
                        taps_val = 17'($urandom_range(8, 2));
                    case ($urandom_range(4))
                        0:       decay_val = '0;
                        1:       decay_val = 17'($urandom);
                        default: decay_val = 17'($urandom_range(65536, 40000));
                    endcase
                    if ($urandom_range(3) == 0)
                        scale_val = 17'($urandom);
                    else
                        scale_val = 17'($urandom_range(8192, 1024));
                end
            endcase

            write_register(CFG_DELAY_LENGTH, delay_val);
            write_register(CFG_TAP_COUNT, taps_val);
            write_register(CFG_DECAY_FACTOR, decay_val);
            write_register(CFG_OUTPUT_SCALE, scale_val);
            cfg_chan.valid <= 1'b0;

            // Samples: mostly full-range, some at the rails, some near zero.
            repeat (PHASE_SAMPLES)
            begin
                logic signed [SAMPLE_BITS-1:0] dry;

                case ($urandom_range(9))
                    0:       dry = 16'sh7FFF;
                    1:       dry = 16'sh8000;
                    2:       dry = 16'(int'($urandom_range(64)) - 32);
                    default: dry = 16'($urandom);
                endcase
                send_sample(dry, 1'b0, '0);
            end
        end

        drain_results();
        steady_flow = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_mix.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
